[design/brf_pkg.sv]
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and constants for the byte ring FIFO with position markers.
// ----------------------------------------------------------------------------
package brf_pkg;

    // Pointers, counts and the capacity register are all twelve bits wide.
    localparam int PTR_W = 12;

    typedef enum logic [2:0] {
        OP_WRITE   = 3'd0,
        OP_READ    = 3'd1,
        OP_PEEK    = 3'd2,
        OP_ADV_RD  = 3'd3,
        OP_ADV_WR  = 3'd4,
        OP_CLEAR   = 3'd5,
        OP_MARK    = 3'd6,
        OP_FLAG    = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_HIT    = 2'd2
    } kind_t;

    // Requests from the sequencer to the marker queue.
    typedef struct packed {
        logic             push;
        logic             pop;
        logic             clear;
        logic [PTR_W-1:0] push_pos;
    } mq_ctl_t;

    // Marker queue status seen by the sequencer.
    typedef struct packed {
        logic             empty;
        logic             full;
        logic [PTR_W-1:0] head_pos;
    } mq_st_t;

endpackage

[design/brf_mem.sv]
// ----------------------------------------------------------------------------
// brf_mem
// Byte store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module brf_mem
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // The read data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/brf_markq.sv]
// ----------------------------------------------------------------------------
// brf_markq
// Circular queue of marker positions, popped at the head only.
// ----------------------------------------------------------------------------
module brf_markq
    import brf_pkg::*;
#(
    parameter int MARK_DEPTH = 8
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  mq_ctl_t ctl,
    output mq_st_t  st
);

    localparam int MW = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
    localparam int CW = $clog2(MARK_DEPTH + 1);
    localparam logic [MW-1:0] LAST = MW'(MARK_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(MARK_DEPTH);

    logic [PTR_W-1:0] entry [MARK_DEPTH];
    logic [MW-1:0]    head_reg, head_next;
    logic [MW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        if (ctl.clear)
        begin
            head_next = '0;
            tail_next = '0;
            cnt_next  = '0;
        end
        else if (ctl.push)
        begin
            tail_next = (tail_reg == LAST) ? '0 : tail_reg + 1'b1;
            cnt_next  = cnt_reg + 1'b1;
        end
        else if (ctl.pop)
        begin
            head_next = (head_reg == LAST) ? '0 : head_reg + 1'b1;
            cnt_next  = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push && !ctl.clear)
        begin
            entry[tail_reg] <= ctl.push_pos;
        end
    end

    assign st.empty    = (cnt_reg == '0);
    assign st.full     = (cnt_reg == FULL_CNT);
    assign st.head_pos = entry[head_reg];

endmodule

[design/byte_ring_fifo_with_markers_top.sv]
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_markers_top
// Circular byte FIFO (modulus capacity + 1) with a queue of position markers.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Direction  Payload
//  -------   -------------------  ---------  ------------------------------
//  command   cmd_valid/cmd_stall  in         operation, write_byte, count,
//                                            flag_select, flag_value
//  result    res_valid/res_stall  out        kind, read_byte, fill_level,
//                                            space_left, accepted,
//                                            stream_ended, reading_ended,
//                                            final_item
//  config    APB (psel/penable)   in/out     capacity at byte address 0
//
//  Write, advance, clear, marker and flag items pass through accept, execute
//  and a status result. A read or peek passes through accept, execute, a
//  scan that pops the markers on the read pointer, a sizing step, one hit
//  result per marker and, per data byte, an address step and a data step,
//  set by the single read port of the byte store. When neither a marker
//  nor a byte comes out, a single status result follows instead.
//  Reset clears both pointers, the marker queue and the flags and sets the
//  capacity to 4095 (clamped to DEPTH - 1). The store itself is not cleared.
//  A stalled result holds in the output register; the sequencer waits there
//  and the next command is taken as soon as the last result is loaded.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_markers_top
    import brf_pkg::*;
#(
    parameter int DEPTH      = 4096,
    parameter int MARK_DEPTH = 8,
    parameter int MAX_BURST  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [2:0]  operation,
    input  logic [7:0]  write_byte,
    input  logic [11:0] count,
    input  logic        flag_select,
    input  logic        flag_value,

    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  kind,
    output logic [7:0]  read_byte,
    output logic [11:0] fill_level,
    output logic [11:0] space_left,
    output logic        accepted,
    output logic        stream_ended,
    output logic        reading_ended,
    output logic        final_item,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW = $clog2(MAX_BURST + 1);
    localparam int HW = $clog2(MARK_DEPTH + 1);

    // Largest usable capacity: the pointer modulus may not exceed the store.
    localparam logic [PTR_W-1:0] CAP_MAX   = (DEPTH - 1 > 4095) ? 12'd4095
                                                                : PTR_W'(DEPTH - 1);
    localparam logic [PTR_W-1:0] BURST_LIM = PTR_W'(MAX_BURST);
    localparam logic [PTR_W-1:0] CAP_RESET = 12'd4095;

    // Register index decoded from paddr[2].
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_EXEC = 8'b0000_0010,
        S_SCAN = 8'b0000_0100,
        S_TAKE = 8'b0000_1000,
        S_HIT  = 8'b0001_0000,
        S_BREQ = 8'b0010_0000,
        S_BOUT = 8'b0100_0000,
        S_STAT = 8'b1000_0000
    } state_t;

    // Ring addition of a value that is known to stay below the modulus.
    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] a,
                                                  input logic [PTR_W-1:0] b,
                                                  input logic [PTR_W:0]   m);
        logic [PTR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= m)
        begin
            s = s - m;
        end
        return s[PTR_W-1:0];
    endfunction

    // Command fields, captured at acceptance.
    op_t              op_reg;
    logic [7:0]       wbyte_reg;
    logic [PTR_W-1:0] count_reg;
    logic             fsel_reg;
    logic             fval_reg;

    // Control state.
    state_t           state_reg, state_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] cap_raw_reg, cap_raw_next;
    logic [PTR_W-1:0] usable_reg, usable_next;
    logic             se_flag_reg, se_flag_next;
    logic             re_flag_reg, re_flag_next;
    logic             acc_reg, acc_next;
    logic [HW-1:0]    hits_reg, hits_next;
    logic [TW-1:0]    left_reg, left_next;
    logic [PTR_W-1:0] pos_reg, pos_next;
    logic             res_valid_reg, res_valid_next;

    // Result register payload.
    kind_t            kind_reg;
    logic [7:0]       rbyte_reg;
    logic [PTR_W-1:0] used_o_reg;
    logic [PTR_W-1:0] free_o_reg;
    logic             acc_o_reg;
    logic             se_o_reg;
    logic             re_o_reg;
    logic             final_o_reg;

    logic             out_free;
    logic             out_load;
    kind_t            out_kind;
    logic             out_final;
    logic             cmd_accept;
    logic             cfg_wr;
    logic [PTR_W-1:0] cap_in;
    logic [PTR_W-1:0] cap_clamped;
    logic [PTR_W:0]   modulus;
    logic [PTR_W-1:0] used;
    logic [PTR_W-1:0] room_cnt;
    logic [PTR_W-1:0] gap;
    logic [PTR_W-1:0] take;
    logic [PTR_W-1:0] step;
    logic [PTR_W-1:0] nxt_pos;

    logic             mem_we;
    logic             mem_re;
    logic [7:0]       mem_rdata;
    mq_ctl_t          mq_ctl;
    mq_st_t           mq_st;

    brf_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (AW'(wp_reg)),
        .wr_data (wbyte_reg),
        .rd_en   (mem_re),
        .rd_addr (AW'(pos_reg)),
        .rd_data (mem_rdata)
    );

    brf_markq #(
        .MARK_DEPTH (MARK_DEPTH)
    ) u_markq (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mq_ctl),
        .st    (mq_st)
    );

    // Fill level from the live pointers. Every result reports the state left
    // by its command, so the level is taken from the registers at load time.
    assign modulus  = {1'b0, usable_reg} + 1'b1;
    assign used     = (wp_reg >= rp_reg) ? (wp_reg - rp_reg)
                                         : PTR_W'(modulus - {1'b0, rp_reg} + {1'b0, wp_reg});
    assign room_cnt = usable_reg - used;
    assign gap      = (mq_st.head_pos >= rp_reg)
                      ? (mq_st.head_pos - rp_reg)
                      : PTR_W'({1'b0, mq_st.head_pos} + modulus - {1'b0, rp_reg});
    assign nxt_pos  = ring_add(pos_reg, 12'd1, modulus);

    assign out_free   = !res_valid_reg || !res_stall;
    assign cmd_stall  = (state_reg != S_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;

    // Configuration: capacity is clamped once, when it is written.
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
    assign cap_in = pwdata[PTR_W-1:0];

    always_comb
    begin
        cap_clamped = cap_in;
        if (cap_in == '0)
        begin
            cap_clamped = 12'd1;
        end
        else if (cap_in > CAP_MAX)
        begin
            cap_clamped = CAP_MAX;
        end
    end

    // Burst size: bounded by the request, the held bytes, the burst limit
    // and the distance to the next pending marker.
    always_comb
    begin
        take = count_reg;
        if (used < take)
        begin
            take = used;
        end
        if (BURST_LIM < take)
        begin
            take = BURST_LIM;
        end
        if (!mq_st.empty && (gap < take))
        begin
            take = gap;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        rp_next      = rp_reg;
        wp_next      = wp_reg;
        cap_raw_next = cap_raw_reg;
        usable_next  = usable_reg;
        se_flag_next = se_flag_reg;
        re_flag_next = re_flag_reg;
        acc_next     = acc_reg;
        hits_next    = hits_reg;
        left_next    = left_reg;
        pos_next     = pos_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mq_ctl       = '0;
        out_load     = 1'b0;
        out_kind     = KIND_STATUS;
        out_final    = 1'b1;
        step         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                acc_next   = 1'b0;
                state_next = S_STAT;
                unique case (op_reg)
                    OP_WRITE:
                    begin
                        if (used < usable_reg)
                        begin
                            mem_we   = 1'b1;
                            wp_next  = ring_add(wp_reg, 12'd1, modulus);
                            acc_next = 1'b1;
                        end
                    end
                    OP_READ, OP_PEEK:
                    begin
                        if ((count_reg != '0) &&
                            !((op_reg == OP_PEEK) && (count_reg > usable_reg)))
                        begin
                            hits_next  = '0;
                            state_next = S_SCAN;
                        end
                    end
                    OP_ADV_RD:
                    begin
                        step    = (count_reg > used) ? used : count_reg;
                        rp_next = ring_add(rp_reg, step, modulus);
                    end
                    OP_ADV_WR:
                    begin
                        step    = (count_reg > room_cnt) ? room_cnt : count_reg;
                        wp_next = ring_add(wp_reg, step, modulus);
                    end
                    OP_CLEAR:
                    begin
                        rp_next      = '0;
                        wp_next      = '0;
                        mq_ctl.clear = 1'b1;
                    end
                    OP_MARK:
                    begin
                        if (!mq_st.full)
                        begin
                            mq_ctl.push     = 1'b1;
                            mq_ctl.push_pos = wp_reg;
                            acc_next        = 1'b1;
                        end
                    end
                    OP_FLAG:
                    begin
                        if (fsel_reg)
                        begin
                            re_flag_next = fval_reg;
                        end
                        else
                        begin
                            se_flag_next = fval_reg;
                        end
                    end
                endcase
            end

            S_SCAN:
            begin
                // Pop one marker a cycle while the head sits on the read pointer.
                if (!mq_st.empty && (mq_st.head_pos == rp_reg))
                begin
                    mq_ctl.pop = 1'b1;
                    hits_next  = hits_reg + 1'b1;
                end
                else
                begin
                    state_next = S_TAKE;
                end
            end

            S_TAKE:
            begin
                left_next = TW'(take);
                pos_next  = rp_reg;
                if (op_reg == OP_READ)
                begin
                    rp_next = ring_add(rp_reg, take, modulus);
                end
                if (hits_reg != '0)
                begin
                    state_next = S_HIT;
                end
                else if (take != '0)
                begin
                    state_next = S_BREQ;
                end
                else
                begin
                    state_next = S_STAT;
                end
            end

            S_HIT:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    out_kind  = KIND_HIT;
                    out_final = (hits_reg == HW'(1)) && (left_reg == '0);
                    hits_next = hits_reg - 1'b1;
                    if (hits_reg == HW'(1))
                    begin
                        state_next = (left_reg != '0) ? S_BREQ : S_IDLE;
                    end
                end
            end

            S_BREQ:
            begin
                mem_re     = 1'b1;
                state_next = S_BOUT;
            end

            S_BOUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_kind   = KIND_DATA;
                    out_final  = (left_reg == TW'(1));
                    left_next  = left_reg - 1'b1;
                    pos_next   = nxt_pos;
                    state_next = (left_reg == TW'(1)) ? S_IDLE : S_BREQ;
                end
            end

            S_STAT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Capacity write empties ring; user writes only while idle, unchecked.
        if (cfg_wr)
        begin
            cap_raw_next = cap_in;
            usable_next  = cap_clamped;
            rp_next      = '0;
            wp_next      = '0;
            mq_ctl.clear = 1'b1;
        end
    end

    assign res_valid_next = out_load || (res_valid_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rp_reg        <= '0;
            wp_reg        <= '0;
            cap_raw_reg   <= CAP_RESET;
            usable_reg    <= CAP_MAX;
            se_flag_reg   <= 1'b0;
            re_flag_reg   <= 1'b0;
            acc_reg       <= 1'b0;
            hits_reg      <= '0;
            left_reg      <= '0;
            pos_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            cap_raw_reg   <= cap_raw_next;
            usable_reg    <= usable_next;
            se_flag_reg   <= se_flag_next;
            re_flag_reg   <= re_flag_next;
            acc_reg       <= acc_next;
            hits_reg      <= hits_next;
            left_reg      <= left_next;
            pos_reg       <= pos_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            op_reg    <= op_t'(operation);
            wbyte_reg <= write_byte;
            count_reg <= count;
            fsel_reg  <= flag_select;
            fval_reg  <= flag_value;
        end
        if (out_load)
        begin
            kind_reg    <= out_kind;
            rbyte_reg   <= (out_kind == KIND_DATA) ? mem_rdata : 8'd0;
            used_o_reg  <= used;
            free_o_reg  <= room_cnt;
            acc_o_reg   <= acc_reg;
            se_o_reg    <= se_flag_reg && (used == '0);
            re_o_reg    <= re_flag_reg;
            final_o_reg <= out_final;
        end
    end

    assign res_valid     = res_valid_reg;
    assign kind          = kind_reg;
    assign read_byte     = rbyte_reg;
    assign fill_level    = used_o_reg;
    assign space_left    = free_o_reg;
    assign accepted      = acc_o_reg;
    assign stream_ended  = se_o_reg;
    assign reading_ended = re_o_reg;
    assign final_item    = final_o_reg;

    assign pready = 1'b1;
    assign prdata = {20'd0, cap_raw_reg};

    // The ring never holds more than its usable capacity.
    assert property (@(posedge clk) disable iff (!rst_n) used <= usable_reg)
        else $error("fill level exceeds usable capacity");

    // Both pointers stay below the ring modulus.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rp_reg <= usable_reg) && (wp_reg <= usable_reg))
        else $error("pointer outside ring modulus");

    // A marker is popped only when the queue holds one.
    assert property (@(posedge clk) disable iff (!rst_n) mq_ctl.pop |-> !mq_st.empty)
        else $error("marker pop on empty queue");

    // The byte output phase always has a byte left to deliver.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BOUT) |-> (left_reg != '0))
        else $error("data phase entered with no bytes left");

endmodule

[tb/tb_byte_ring_fifo_with_markers_top.sv]
// ----------------------------------------------------------------------------
// tb_byte_ring_fifo_with_markers_top
// Self-checking bench for the byte ring FIFO with position markers.
// Commands are built ahead of time and queued to a clocked driver. A clocked
// monitor predicts the result items of every accepted command from a local
// copy of the FIFO state and checks each result item against them in order.
// The run walks through several capacity settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_byte_ring_fifo_with_markers_top
    import brf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = 4096;
    localparam int MARK_DEPTH = 8;
    localparam int MAX_BURST  = 16;

    // Register map: capacity is the only register, at byte address zero.
    localparam logic [2:0] ADDR_CAPACITY = 3'd0;

    localparam int RANDOM_PER_PHASE = 50;
    localparam int IDLE_PERCENT     = 30;
    localparam int HOLD_CYCLES      = 300;
    localparam int SETTLE_CYCLES    = 8;
    localparam int TAIL_CYCLES      = 50;
    localparam int CYCLE_LIMIT      = 600000;

    // One command item as it travels on the command channel.
    typedef struct packed {
        op_t         op;
        logic [7:0]  wbyte;
        logic [11:0] cnt;
        logic        fsel;
        logic        fval;
    } fifo_cmd_t;

    // One result item as it leaves the block.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  rbyte;
        logic [11:0] used;
        logic [11:0] room;
        logic        acc;
        logic        eos;
        logic        eor;
        logic        fin;
    } fifo_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    logic [2:0]  operation = 3'd0;
    logic [7:0]  write_byte = 8'd0;
    logic [11:0] count = 12'd0;
    logic        flag_select = 1'b0;
    logic        flag_value = 1'b0;

    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  read_byte;
    logic [11:0] fill_level;
    logic [11:0] space_left;
    logic        accepted;
    logic        stream_ended;
    logic        reading_ended;
    logic        final_item;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    byte_ring_fifo_with_markers_top #(
        .DEPTH      (DEPTH),
        .MARK_DEPTH (MARK_DEPTH),
        .MAX_BURST  (MAX_BURST)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .operation     (operation),
        .write_byte    (write_byte),
        .count         (count),
        .flag_select   (flag_select),
        .flag_value    (flag_value),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .kind          (kind),
        .read_byte     (read_byte),
        .fill_level    (fill_level),
        .space_left    (space_left),
        .accepted      (accepted),
        .stream_ended  (stream_ended),
        .reading_ended (reading_ended),
        .final_item    (final_item),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // FIFO state copies. Copy 0 follows the commands the block accepts and
    // produces the expected result items. Copy 1 runs ahead while commands
    // are being built, so the stimulus can see what a command would do.
    // ------------------------------------------------------------------------
    logic [7:0]  ring_mem    [2][DEPTH];
    bit          mem_written [2][DEPTH];
    int          rd_ptr      [2];
    int          wr_ptr      [2];
    int          mark_pos    [2][MARK_DEPTH];
    int          mark_cnt    [2];
    bit          eos_flag    [2];
    bit          eor_flag    [2];
    int          cap_reg     [2];

    fifo_cmd_t   pending_cmds[$];
    fifo_res_t   expected_results[$];

    int          items_queued = 0;
    int          items_taken = 0;
    int          results_seen = 0;
    int          mismatches = 0;
    int          cycles = 0;
    logic        cmd_fire = 1'b0;

    bit          calm = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;

    // The pointer modulus is the clamped capacity plus one.
    function automatic int ring_mod(input int s);
        int c;
        c = cap_reg[s] & 'hFFF;
        if (c < 1)
            c = 1;
        if (c > DEPTH - 1)
            c = DEPTH - 1;
        return c + 1;
    endfunction

    function automatic int held(input int s);
        if (wr_ptr[s] >= rd_ptr[s])
            return wr_ptr[s] - rd_ptr[s];
        return ring_mod(s) - (rd_ptr[s] - wr_ptr[s]);
    endfunction

    // Sizes a read or peek: how many markers sit on the read pointer and
    // how many bytes follow them before the burst is cut short.
    function automatic void plan_burst(input int s, input op_t op, input logic [11:0] n,
                                       output int hits, output int take);
        int m;
        int used;
        int gap;
        int k;
        m = ring_mod(s);
        used = held(s);
        hits = 0;
        take = 0;
        if (n == 12'd0 || (op == OP_PEEK && int'(n) > m - 1))
            return;
        take = n;
        if (take > used)
            take = used;
        if (take > MAX_BURST)
            take = MAX_BURST;
        for (k = 0; k < mark_cnt[s]; k++)
        begin
            if (mark_pos[s][k] != rd_ptr[s])
            begin
                gap = (mark_pos[s][k] + m - rd_ptr[s]) % m;
                if (take > gap)
                    take = gap;
                break;
            end
            hits++;
        end
    endfunction

    function automatic void reset_ring(input int s);
        rd_ptr[s] = 0;
        wr_ptr[s] = 0;
        mark_cnt[s] = 0;
    endfunction

    // Applies one command to a state copy. With record set, the result
    // items it causes are appended to the expected results.
    task automatic fifo_step(input int s, input fifo_cmd_t c, input bit record);
        int m;
        int usable;
        int used;
        int hits;
        int take;
        int total;
        int pos;
        int n;
        int k;
        bit acc;
        logic [7:0] data [MAX_BURST];
        fifo_res_t r;
        m = ring_mod(s);
        usable = m - 1;
        used = held(s);
        acc = 1'b0;
        hits = 0;
        take = 0;
        case (c.op)
            OP_WRITE:
            begin
                if (used < usable)
                begin
                    ring_mem[s][wr_ptr[s]] = c.wbyte;
                    mem_written[s][wr_ptr[s]] = 1'b1;
                    wr_ptr[s] = (wr_ptr[s] + 1) % m;
                    acc = 1'b1;
                end
            end
            OP_READ, OP_PEEK:
            begin
                plan_burst(s, c.op, c.cnt, hits, take);
                pos = rd_ptr[s];
                for (k = 0; k < take; k++)
                begin
                    data[k] = ring_mem[s][pos];
                    pos = (pos + 1) % m;
                end
                // Every marker found on the read pointer is consumed.
                for (k = 0; k + hits < MARK_DEPTH; k++)
                    mark_pos[s][k] = mark_pos[s][k + hits];
                mark_cnt[s] = mark_cnt[s] - hits;
                if (c.op == OP_READ)
                    rd_ptr[s] = pos;
            end
            OP_ADV_RD:
            begin
                n = c.cnt;
                if (n > used)
                    n = used;
                rd_ptr[s] = (rd_ptr[s] + n) % m;
            end
            OP_ADV_WR:
            begin
                n = c.cnt;
                if (n > usable - used)
                    n = usable - used;
                wr_ptr[s] = (wr_ptr[s] + n) % m;
            end
            OP_CLEAR:
                reset_ring(s);
            OP_MARK:
            begin
                if (mark_cnt[s] < MARK_DEPTH)
                begin
                    mark_pos[s][mark_cnt[s]] = wr_ptr[s];
                    mark_cnt[s]++;
                    acc = 1'b1;
                end
            end
            default:
            begin
                if (c.fsel == 1'b0)
                    eos_flag[s] = c.fval;
                else
                    eor_flag[s] = c.fval;
            end
        endcase

        if (!record)
            return;
        used = held(s);
        total = hits + take;
        if (total == 0)
            total = 1;
        for (k = 0; k < total; k++)
        begin
            if (hits + take == 0)
                r.kind = KIND_STATUS;
            else if (k < hits)
                r.kind = KIND_HIT;
            else
                r.kind = KIND_DATA;
            r.rbyte = (r.kind == KIND_DATA) ? data[k - hits] : 8'h00;
            r.used = 12'(used);
            r.room = 12'(usable - used);
            r.acc = acc;
            r.eos = eos_flag[s] && (used == 0);
            r.eor = eor_flag[s];
            r.fin = (k == total - 1);
            expected_results.push_back(r);
        end
    endtask

    function automatic fifo_cmd_t make_cmd(input op_t op, input logic [7:0] b,
                                           input logic [11:0] n, input logic fs,
                                           input logic fv);
        fifo_cmd_t c;
        c.op = op;
        c.wbyte = b;
        c.cnt = n;
        c.fsel = fs;
        c.fval = fv;
        return c;
    endfunction

    // Mostly writes, bursts and markers, so the ring fills, wraps and
    // meets its markers; the rest clears, skips and toggles flags.
    function automatic fifo_cmd_t random_cmd();
        fifo_cmd_t c;
        int r;
        int top;
        r = $urandom_range(0, 99);
        if (r < 36)
            c.op = OP_WRITE;
        else if (r < 56)
            c.op = OP_READ;
        else if (r < 64)
            c.op = OP_PEEK;
        else if (r < 70)
            c.op = OP_ADV_RD;
        else if (r < 75)
            c.op = OP_ADV_WR;
        else if (r < 78)
            c.op = OP_CLEAR;
        else if (r < 90)
            c.op = OP_MARK;
        else
            c.op = OP_FLAG;
        c.wbyte = 8'($urandom);
        top = ring_mod(1) + 1;
        if (top > 4095)
            top = 4095;
        r = $urandom_range(0, 99);
        if (r < 50)
            c.cnt = 12'($urandom_range(0, 20));
        else if (r < 70)
            c.cnt = 12'($urandom_range(0, top));
        else if (r < 85)
            c.cnt = 12'($urandom_range(1, MAX_BURST));
        else
            c.cnt = 12'($urandom);
        // Large write-pointer skips would mostly hand out unwritten bytes.
        if (c.op == OP_ADV_WR && $urandom_range(0, 99) < 80)
            c.cnt = 12'($urandom_range(0, 4));
        c.fsel = 1'($urandom);
        c.fval = 1'($urandom);
        return c;
    endfunction

    // Queues a command for the driver. A read or peek that would hand out a
    // byte never written in the store is turned into a read-pointer skip,
    // since the content of such a byte is not defined.
    task automatic queue_cmd(input fifo_cmd_t c);
        fifo_cmd_t it;
        int hits;
        int take;
        int m;
        int k;
        bit safe;
        it = c;
        if (it.op == OP_READ || it.op == OP_PEEK)
        begin
            plan_burst(1, it.op, it.cnt, hits, take);
            m = ring_mod(1);
            safe = 1'b1;
            for (k = 0; k < take; k++)
                if (!mem_written[1][(rd_ptr[1] + k) % m])
                    safe = 1'b0;
            if (!safe)
                it.op = OP_ADV_RD;
        end
        fifo_step(1, it, 1'b0);
        pending_cmds.push_back(it);
        items_queued++;
    endtask

    // A write only happens while the block is idle. Both state copies take
    // the new capacity, which also empties the ring and drops the markers.
    task automatic write_capacity(input int value);
        int s;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_CAPACITY;
        pwdata <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        for (s = 0; s < 2; s++)
        begin
            cap_reg[s] = value & 'hFFF;
            reset_ring(s);
        end
        @(posedge clk);
    endtask

    // Waits until every queued command has been taken and answered.
    task automatic drain(input int settle);
        while (items_taken != items_queued || expected_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver. Changes the command channel at the falling edge only, and only
    // once the current item has been taken or none is on offer.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        fifo_cmd_t c;
        if (!rst_n)
            cmd_valid <= 1'b0;
        else if (!cmd_valid || cmd_fire)
        begin
            if (pending_cmds.size() != 0 &&
                (calm || $urandom_range(0, 99) >= IDLE_PERCENT))
            begin
                c = pending_cmds.pop_front();
                operation <= c.op;
                write_byte <= c.wbyte;
                count <= c.cnt;
                flag_select <= c.fsel;
                flag_value <= c.fval;
                cmd_valid <= 1'b1;
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. Stalls at random, except in the calm phase, and once holds
    // off for a long stretch so the block backs up into its command input.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            res_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            res_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            res_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // ------------------------------------------------------------------------
    // Monitor. At each rising edge an accepted command is predicted and an
    // accepted result item is checked against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        fifo_cmd_t c;
        fifo_res_t got;
        fifo_res_t want;
        if (!rst_n)
            cmd_fire <= 1'b0;
        else
        begin
            cmd_fire <= cmd_valid && !cmd_stall;
            if (cmd_valid && !cmd_stall)
            begin
                c = make_cmd(op_t'(operation), write_byte, count, flag_select, flag_value);
                fifo_step(0, c, 1'b1);
                items_taken <= items_taken + 1;
            end
            if (res_valid && !res_stall)
            begin
                got.kind = kind_t'(kind);
                got.rbyte = read_byte;
                got.used = fill_level;
                got.room = space_left;
                got.acc = accepted;
                got.eos = stream_ended;
                got.eor = reading_ended;
                got.fin = final_item;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with nothing expected: kind=%0d byte=%02h",
                                 results_seen, got.kind, got.rbyte);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("result %0d expected kind=%0d byte=%02h used=%0d free=%0d",
                                     results_seen, want.kind, want.rbyte, want.used,
                                     want.room);
                            $display("    expected acc=%b eos=%b eor=%b fin=%b",
                                     want.acc, want.eos, want.eor, want.fin);
                            $display("result %0d actual   kind=%0d byte=%02h used=%0d free=%0d",
                                     results_seen, got.kind, got.rbyte, got.used,
                                     got.room);
                            $display("    actual   acc=%b eos=%b eor=%b fin=%b",
                                     got.acc, got.eos, got.eor, got.fin);
                        end
                    end
                end
                results_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, a few items at the reset capacity, a directed pass at
    // a tiny capacity, then random phases over a spread of capacities.
    // ------------------------------------------------------------------------
    initial
    begin
        int caps [10];
        int ph;
        int i;
        int s;
        caps = '{4, 0, 1, 4095, 9, 37, 16, 4095, 3, 200};
        for (s = 0; s < 2; s++)
        begin
            for (i = 0; i < DEPTH; i++)
                mem_written[s][i] = 1'b0;
            reset_ring(s);
            eos_flag[s] = 1'b0;
            eor_flag[s] = 1'b0;
            cap_reg[s] = 4095;
        end

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The reset capacity shows up in the free count.
        queue_cmd(make_cmd(OP_WRITE, 8'h3C, 12'd0, 1'b0, 1'b0));
        queue_cmd(make_cmd(OP_PEEK, 8'h00, 12'd1, 1'b0, 1'b0));
        queue_cmd(make_cmd(OP_READ, 8'h00, 12'd1, 1'b0, 1'b0));
        drain(SETTLE_CYCLES);

        for (ph = 0; ph < 10; ph++)
        begin
            write_capacity(caps[ph]);
            calm = (ph == 3);
            hold_req = (ph == 5);
            if (ph == 0)
            begin
                // Bursts of length zero and peeks longer than the ring.
                queue_cmd(make_cmd(OP_READ, 8'h00, 12'd0, 1'b0, 1'b0));
                queue_cmd(make_cmd(OP_PEEK, 8'h00, 12'd0, 1'b0, 1'b0));
                queue_cmd(make_cmd(OP_PEEK, 8'h00, 12'hFFF, 1'b0, 1'b0));
                // Both flags set while the ring is empty.
                queue_cmd(make_cmd(OP_FLAG, 8'h00, 12'd0, 1'b0, 1'b1));
                queue_cmd(make_cmd(OP_FLAG, 8'h00, 12'd0, 1'b1, 1'b1));
                // A marker on the read pointer, then one two bytes later.
                queue_cmd(make_cmd(OP_MARK, 8'h00, 12'd0, 1'b0, 1'b0));
                queue_cmd(make_cmd(OP_WRITE, 8'h00, 12'd0, 1'b0, 1'b0));
                queue_cmd(make_cmd(OP_WRITE, 8'hFF, 12'd0, 1'b0, 1'b0));
                queue_cmd(make_cmd(OP_MARK, 8'h00, 12'd0, 1'b0, 1'b0));
                queue_cmd(make_cmd(OP_WRITE, 8'h5A, 12'd0, 1'b0, 1'b0));
                queue_cmd(make_cmd(OP_WRITE, 8'hA5, 12'd0, 1'b0, 1'b0));
                // The ring is full now, so this byte is dropped.
                queue_cmd(make_cmd(OP_WRITE, 8'h11, 12'd0, 1'b0, 1'b0));
                // Peek pops the first marker and stops at the second one.
                queue_cmd(make_cmd(OP_PEEK, 8'h00, 12'd4, 1'b0, 1'b0));
                queue_cmd(make_cmd(OP_READ, 8'h00, 12'hFFF, 1'b0, 1'b0));
                queue_cmd(make_cmd(OP_READ, 8'h00, 12'd1, 1'b0, 1'b0));
                // Pointer skips far beyond the free and the held bytes.
                queue_cmd(make_cmd(OP_ADV_WR, 8'h00, 12'hFFF, 1'b0, 1'b0));
                queue_cmd(make_cmd(OP_ADV_RD, 8'h00, 12'hFFF, 1'b0, 1'b0));
                // Fill the marker queue; the last placement is refused.
                for (i = 0; i <= MARK_DEPTH; i++)
                    queue_cmd(make_cmd(OP_MARK, 8'h00, 12'd0, 1'b0, 1'b0));
                // All queued markers sit on the read pointer: one hit each.
                queue_cmd(make_cmd(OP_READ, 8'h00, 12'd1, 1'b0, 1'b0));
                queue_cmd(make_cmd(OP_CLEAR, 8'h00, 12'd0, 1'b0, 1'b0));
            end
            else
            begin
                for (i = 0; i < RANDOM_PER_PHASE; i++)
                    queue_cmd(random_cmd());
            end
            drain(SETTLE_CYCLES);
            calm = 1'b0;
        end

        drain(TAIL_CYCLES);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
